// ===== sv/v3n_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared constants for the vector normalizer.
// ----------------------------------------------------------------------------
package v3n_pkg;
  localparam int unsigned IN_WIDTH_DEF  = 16;
  localparam int unsigned FRAC_BITS_DEF = 14;
endpackage
`default_nettype wire

// ===== sv/v3n_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_if
// Valid/ready channel carrying a parameterized payload.
// ----------------------------------------------------------------------------
interface v3n_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/vector3_normalize_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_normalize_top
// Unit vector of a signed 3-component vector, signed Q1.FRAC_BITS out.
// ----------------------------------------------------------------------------
// Accepts one vector every cycle unless the output stalls. The pipeline is a
// magnitude stage, a square stage, a sum stage, IN_WIDTH + 1 stages of the
// pipelined square root (one per root bit), a stage that substitutes a length
// of one for a zero vector, IN_WIDTH + FRAC_BITS stages of the three dividers
// (one per quotient bit) and the output register. A stall freezes the whole
// pipeline; a zero vector gives zero outputs with zero_length set.
module vector3_normalize_top
  import v3n_pkg::*;
#(
  parameter int unsigned IN_WIDTH  = IN_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  v3n_if.sink      vin,
  v3n_if.source    vout
);
  localparam int unsigned MW = IN_WIDTH;             // magnitude width
  localparam int unsigned SW = 2 * MW + 2;           // sum width, even
  localparam int unsigned RS = SW / 2;               // root steps
  localparam int unsigned NW = MW + FRAC_BITS;       // numerator width
  localparam int unsigned DW = RS;                   // divisor width
  localparam int unsigned OW = FRAC_BITS + 2;

  logic en;
  assign en = !vout.valid || vout.ready;
  assign vin.ready = en;

  // Stage 0: magnitudes and signs
  logic              v0;
  logic [2:0][MW-1:0] mag0;
  logic [2:0]         neg0;
  logic [2:0][IN_WIDTH-1:0] raw;
  assign raw[0] = vin.data.vec_x[IN_WIDTH-1:0];
  assign raw[1] = vin.data.vec_y[IN_WIDTH-1:0];
  assign raw[2] = vin.data.vec_z[IN_WIDTH-1:0];
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= vin.valid;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg0[i] <= raw[i][IN_WIDTH-1];
        mag0[i] <= raw[i][IN_WIDTH-1] ? MW'(-raw[i]) : raw[i];
      end
    end
  end

  // Stage 1: squares
  logic               v1;
  logic [2:0][2*MW-1:0] sq1;
  logic [2:0][MW-1:0] mag1;
  logic [2:0]         neg1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      for (int i = 0; i < 3; i++) sq1[i] <= mag0[i] * mag0[i];
      mag1 <= mag0;
      neg1 <= neg0;
    end
  end

  // Stage 2: sum of squares
  logic          v2;
  logic [SW-1:0] sum2;
  logic [2:0][MW-1:0] mag2;
  logic [2:0]    neg2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      sum2 <= SW'(sq1[0]) + SW'(sq1[1]) + SW'(sq1[2]);
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  // Square root pipeline, side data delayed alongside
  logic [RS:0]          sv;
  logic [RS:0][SW-1:0]  srem;
  logic [RS:0][SW-1:0]  sres;
  logic [RS:0][2:0][MW-1:0] smag;
  logic [RS:0][2:0]     sneg;
  assign sv[0]   = v2;
  assign srem[0] = sum2;
  assign sres[0] = '0;
  assign smag[0] = mag2;
  assign sneg[0] = neg2;
  for (genvar k = 0; k < RS; k++) begin : g_sqrt
    v3n_sqrt_stage #(.SW(SW), .STEP(k)) u_stage (
      .clk(clk), .rst(rst), .en(en), .vin(sv[k]),
      .rem_in(srem[k]), .res_in(sres[k]),
      .vout(sv[k+1]), .rem(srem[k+1]), .res(sres[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        smag[k+1] <= smag[k];
        sneg[k+1] <= sneg[k];
      end
    end
  end

  // Zero-length substitute
  logic          vd;
  logic [DW-1:0] dend;
  logic          zd;
  logic [2:0][NW-1:0] numd;
  logic [2:0]    negd;
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= sv[RS];
    if (en) begin
      zd   <= (sres[RS] == '0);
      dend <= (sres[RS] == '0) ? DW'(1) : sres[RS][DW-1:0];
      for (int i = 0; i < 3; i++) numd[i] <= {smag[RS][i], FRAC_BITS'(0)};
      negd <= sneg[RS];
    end
  end

  // Divider pipeline
  logic [NW:0]               dv;
  logic [NW:0][DW-1:0]       dden;
  logic [NW:0][2:0][DW:0]    drem;
  logic [NW:0][2:0][NW-1:0]  dnum;
  logic [NW:0][2:0]          dneg;
  logic [NW:0]               dz;
  assign dv[0]   = vd;
  assign dden[0] = dend;
  assign drem[0] = '0;
  assign dnum[0] = numd;
  assign dneg[0] = negd;
  assign dz[0]   = zd;
  for (genvar k = 0; k < NW; k++) begin : g_div
    v3n_div_stage #(.NW(NW), .DW(DW)) u_stage (
      .clk(clk), .rst(rst), .en(en), .vin(dv[k]),
      .den(dden[k]), .prem(drem[k]), .num(dnum[k]),
      .vout(dv[k+1]), .den_o(dden[k+1]), .prem_o(drem[k+1]), .num_o(dnum[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        dneg[k+1] <= dneg[k];
        dz[k+1]   <= dz[k];
      end
    end
  end

  // Output register: apply signs
  logic [2:0][OW-1:0] q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = dneg[NW][i] ? OW'(-dnum[NW][i]) : OW'(dnum[NW][i]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) vout.valid <= 1'b0;
    else if (en) vout.valid <= dv[NW];
    if (en) begin
      vout.data.unit_x      <= q[0];
      vout.data.unit_y      <= q[1];
      vout.data.unit_z      <= q[2];
      vout.data.zero_length <= dz[NW];
    end
  end
endmodule
`default_nettype wire

// ===== sv/v3n_sqrt_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_sqrt_stage
// One digit step of the restoring square root, one register stage.
// ----------------------------------------------------------------------------
module v3n_sqrt_stage #(
  parameter int unsigned SW = 34,
  parameter int unsigned STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vin,
  input  wire logic [SW-1:0] rem_in,
  input  wire logic [SW-1:0] res_in,
  output logic               vout,
  output logic [SW-1:0]      rem,
  output logic [SW-1:0]      res
);
  localparam int unsigned POS = SW - 2 - 2 * STEP;
  logic [SW-1:0] bitv;
  logic [SW-1:0] trial;
  logic [SW-1:0] rem_next;
  logic [SW-1:0] res_next;

  // Try one root digit
  always_comb begin
    bitv  = '0;
    bitv[POS] = 1'b1;
    trial = res_in + bitv;
    if (rem_in >= trial) begin
      rem_next = rem_in - trial;
      res_next = (res_in >> 1) + bitv;
    end else begin
      rem_next = rem_in;
      res_next = res_in >> 1;
    end
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      rem <= rem_next;
      res <= res_next;
    end
  end
endmodule
`default_nettype wire

// ===== sv/v3n_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_div_stage
// One quotient bit for three restoring dividers sharing a divisor.
// ----------------------------------------------------------------------------
module v3n_div_stage #(
  parameter int unsigned NW = 31,
  parameter int unsigned DW = 17
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              vin,
  input  wire logic [DW-1:0]     den,
  input  wire logic [2:0][DW:0]  prem,
  input  wire logic [2:0][NW-1:0] num,
  output logic                   vout,
  output logic [DW-1:0]          den_o,
  output logic [2:0][DW:0]       prem_o,
  output logic [2:0][NW-1:0]     num_o
);
  logic [2:0][DW:0]   sh;
  logic [2:0][DW:0]   rem_next;
  logic [2:0][NW-1:0] num_next;

  // Shift in next numerator bit, subtract if it fits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = {prem[i][DW-1:0], num[i][NW-1]};
      num_next[i] = {num[i][NW-2:0], 1'b0};
      if (sh[i] >= {1'b0, den}) begin
        rem_next[i] = sh[i] - {1'b0, den};
        num_next[i][0] = 1'b1;
      end else begin
        rem_next[i] = sh[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      den_o  <= den;
      prem_o <= rem_next;
      num_o  <= num_next;
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_vector3_normalize_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize_top
// Self-checking bench for the 3-component vector normalizer.
// ----------------------------------------------------------------------------
// Every accepted vector is normalized by an in-bench fixed-point predictor.
// The unit vector it gives is queued and compared field by field with each
// word the block returns. Directed corner vectors go first, then random
// vectors. Both channel sides idle at random. Once, the sender holds off
// until the block has returned every word it owes.
module tb_vector3_normalize_top;
  import v3n_pkg::*;

  localparam int unsigned IN_W     = IN_WIDTH_DEF;
  localparam int unsigned FRAC_W   = FRAC_BITS_DEF;
  localparam int unsigned OUT_W    = FRAC_W + 2;
  localparam int          LATENCY  = 2 * IN_W + FRAC_W + 6;
  localparam int          N_RANDOM = 400;
  localparam int          DRAIN_AT = 150;
  localparam int          WATCHDOG = 3000;

  typedef struct packed {
    logic signed [IN_W-1:0] vec_x;
    logic signed [IN_W-1:0] vec_y;
    logic signed [IN_W-1:0] vec_z;
  } vec_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    zero_length;
  } unit_word_t;

  logic clk;
  logic rst;

  v3n_if #(.payload_t(vec_word_t))  vin ();
  v3n_if #(.payload_t(unit_word_t)) vout ();

  vector3_normalize_top dut (
    .clk  (clk),
    .rst  (rst),
    .vin  (vin.sink),
    .vout (vout.source)
  );

  vec_word_t  pending_vecs[$];
  unit_word_t expected_units[$];
  int         n_sent;
  int         n_errors;
  int         idle_cycles;
  bit         burst_mode;

  // Floor of the square root, one root bit per step.
  function automatic longint unsigned floor_sqrt(input longint unsigned s);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Unit vector of one input word, truncated toward zero.
  function automatic unit_word_t normalize_vec(input vec_word_t v);
    longint unsigned mag[3];
    bit              neg[3];
    longint unsigned sum_sq;
    longint unsigned len;
    longint unsigned q;
    logic [IN_W-1:0] comp[3];
    logic [OUT_W-1:0] res[3];
    unit_word_t      u;
    comp[0] = v.vec_x;
    comp[1] = v.vec_y;
    comp[2] = v.vec_z;
    sum_sq = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][IN_W-1];
      mag[i] = neg[i] ? ((64'd1 << IN_W) - comp[i]) : comp[i];
      sum_sq += mag[i] * mag[i];
    end
    len = floor_sqrt(sum_sq);
    u.zero_length = (len == 0);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q      = (mag[i] << FRAC_W) / len;
      res[i] = neg[i] ? OUT_W'(-q) : OUT_W'(q);
    end
    u.unit_x = res[0];
    u.unit_y = res[1];
    u.unit_z = res[2];
    return u;
  endfunction

  // Gap length: mostly none, some short, a few long; none in burst mode.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [IN_W-1:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return IN_W'($urandom);
    if (r < 8) return IN_W'(int'($urandom_range(0, 64)) - 32);
    if (r == 8) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return '0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: present queued words, hold while stalled, idle at random.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      vin.valid <= 1'b0;
      vin.data  <= '0;
      send_gap   = 0;
      n_sent     = 0;
    end else begin
      if (vin.valid && vin.ready) begin
        expected_units.push_back(normalize_vec(vin.data));
        n_sent++;
      end
      if (vin.valid && !vin.ready) begin
        // hold the current word
      end else if (send_gap > 0) begin
        send_gap--;
        vin.valid <= 1'b0;
      end else if (pending_vecs.size() != 0 &&
                   !(n_sent == DRAIN_AT && expected_units.size() != 0)) begin
        vin.data  <= pending_vecs.pop_front();
        vin.valid <= 1'b1;
        send_gap   = pick_gap();
        if ($urandom_range(0, 99) == 0) burst_mode = ~burst_mode;
      end else begin
        vin.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each returned word against the oldest expectation.
  int stall_len;
  always @(posedge clk) begin
    unit_word_t want;
    unit_word_t got;
    if (rst) begin
      vout.ready <= 1'b0;
      stall_len   = 0;
    end else begin
      if (vout.valid && vout.ready) begin
        got = vout.data;
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, got);
          n_errors++;
        end else begin
          want = expected_units.pop_front();
          if (got.unit_x !== want.unit_x) begin
            $display("%0t: unit_x expected %0d actual %0d", $time, want.unit_x, got.unit_x);
            n_errors++;
          end
          if (got.unit_y !== want.unit_y) begin
            $display("%0t: unit_y expected %0d actual %0d", $time, want.unit_y, got.unit_y);
            n_errors++;
          end
          if (got.unit_z !== want.unit_z) begin
            $display("%0t: unit_z expected %0d actual %0d", $time, want.unit_z, got.unit_z);
            n_errors++;
          end
          if (got.zero_length !== want.zero_length) begin
            $display("%0t: zero_length expected %0b actual %0b", $time,
                     want.zero_length, got.zero_length);
            n_errors++;
          end
        end
      end
      if (stall_len > 0) begin
        stall_len--;
        vout.ready <= 1'b0;
      end else begin
        stall_len = pick_gap();
        vout.ready <= (stall_len == 0);
      end
    end
  end

  // Watchdog: stop if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (vin.valid && vin.ready) || (vout.valid && vout.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    vec_word_t v;
    n_errors    = 0;
    idle_cycles = 0;
    burst_mode  = 1'b0;
    rst         = 1'b1;
    vin.valid   = 1'b0;
    vin.data    = '0;
    vout.ready  = 1'b0;

    // Corners: zero vector, extremes, single axes, most negative values.
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_vecs.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
    pending_vecs.push_back('{16'sh8000, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sh8000, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sh8000});
    pending_vecs.push_back('{16'sh7fff, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sh7fff, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sh7fff});
    pending_vecs.push_back('{16'sd1, 16'sd0, 16'sd0});
    pending_vecs.push_back('{-16'sd1, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd0, -16'sd1, 16'sd1});
    pending_vecs.push_back('{16'sd1, 16'sd1, 16'sd1});
    pending_vecs.push_back('{-16'sd1, -16'sd1, -16'sd1});
    pending_vecs.push_back('{16'sh7fff, 16'sh8000, 16'sd1});
    pending_vecs.push_back('{16'sd3, -16'sd4, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sh8000, 16'sh7fff, -16'sd1});
    pending_vecs.push_back('{16'sd2, 16'sd3, 16'sd6});
    pending_vecs.push_back('{16'sh5555, 16'shaaaa, 16'sh5555});
    pending_vecs.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa});
    for (int i = 0; i < N_RANDOM; i++) begin
      v.vec_x = rand_comp();
      v.vec_y = rand_comp();
      v.vec_z = rand_comp();
      pending_vecs.push_back(v);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_vecs.size() != 0 || vin.valid || expected_units.size() != 0);
    repeat (LATENCY + 10) @(posedge clk);

    if (n_errors == 0 && expected_units.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
